// ----- rtl/core/pn2d_pkg.sv -----
package pn2d_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned OutFrac = 16;
  localparam int unsigned PermDepth = 256;
  localparam int unsigned PermWidth = 8;
  localparam int unsigned CoordWidth = 24;
  localparam int unsigned NoiseWidth = 18;
  localparam int unsigned UnitWidth = 16;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

endpackage

// ----- rtl/core/pn2d_if.sv -----
interface pn2d_in_if;
  logic valid;
  logic ready;
  logic op;
  logic [7:0] perm_index;
  logic [7:0] perm_value;
  logic [23:0] coord_x;
  logic [23:0] coord_y;
  modport source (output valid, op, perm_index, perm_value, coord_x, coord_y, input ready);
  modport sink (input valid, op, perm_index, perm_value, coord_x, coord_y, output ready);
endinterface

interface pn2d_out_if;
  logic valid;
  logic ready;
  logic signed [17:0] noise;
  logic [15:0] noise_unit;
  modport source (output valid, noise, noise_unit, input ready);
  modport sink (input valid, noise, noise_unit, output ready);
endinterface

// ----- rtl/core/pn2d_ram.sv -----
module pn2d_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/perlin_noise_2d_unit.sv -----
// 2D improved Perlin noise, fully pipelined: one request (load or evaluate) is taken every
// cycle while the output side takes results. An evaluate result passes through two table
// lookups, a corner dot product stage, corner carry stages and four lerp stages, then the
// saturated output register, while the fade (a first step, four multiply and round steps
// and a clamp stage) runs beside them; a load gives no result. The whole pipe advances
// together, so a stall at the output holds every stage and the input. The permutation table
// is held in six copies of a 256x8 RAM (two for the first lookup, one per corner for the
// second), each written by every load; all 256 entries must be loaded before the first
// evaluate. Loads and evaluates may be mixed freely; a load takes effect for every evaluate
// accepted after it.
module perlin_noise_2d_unit #(
  parameter int unsigned FRAC_BITS = pn2d_pkg::FracBitsDefault
) (
  input logic clk,
  input logic rst,
  pn2d_in_if.sink   in_req,
  pn2d_out_if.source out_res
);

  localparam int unsigned F = FRAC_BITS;
  localparam int unsigned AW = 8;
  localparam int unsigned NS = 14;
  // signed working width: fade terms reach 15 in magnitude, lerps stay within +-2^(F+2)
  localparam int unsigned DW = F + 5;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned OutShift = (F < pn2d_pkg::OutFrac) ? pn2d_pkg::OutFrac - F : 0;
  localparam logic signed [DW-1:0] One = DW'(1) <<< F;
  localparam logic signed [DW-1:0] Ten = DW'(10) <<< F;
  localparam logic signed [DW-1:0] Fifteen = DW'(15) <<< F;
  localparam logic signed [PW-1:0] Half = PW'(1) <<< (F - 1);

  // rounded rescale of a product, half toward +inf
  function automatic logic signed [DW-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] w;
    begin
      w = p + Half;
      rnd = DW'(w >>> F);
    end
  endfunction

  function automatic logic signed [DW-1:0] cdot(input logic [1:0] h,
      input logic signed [DW-1:0] dx, input logic signed [DW-1:0] dy);
    logic signed [DW-1:0] r;
    begin
      case (h)
        2'd0: r = dx + dy;
        2'd1: r = dy - dx;
        2'd2: r = -dx - dy;
        default: r = dx - dy;
      endcase
      cdot = r;
    end
  endfunction

  logic adv;
  logic [NS-1:0] vld;
  logic out_valid;

  assign adv = !out_valid || out_res.ready;
  assign in_req.ready = adv;

  logic take;
  logic is_load;
  assign take = in_req.valid && adv;
  assign is_load = take && (in_req.op == pn2d_pkg::OP_LOAD);

  // stage 0 inputs
  logic [AW-1:0] xi, yi, xi1, yi1;
  logic [F-1:0] fx_in, fy_in;
  assign xi = AW'(in_req.coord_x >> F);
  assign yi = AW'(in_req.coord_y >> F);
  assign xi1 = xi + AW'(1);
  assign yi1 = yi + AW'(1);
  assign fx_in = in_req.coord_x[F-1:0];
  assign fy_in = in_req.coord_y[F-1:0];

  // first lookup: perm[X], perm[X+1]
  logic [AW-1:0] pa, pb;
  logic [AW-1:0] ha0, ha1, hb0, hb1;

  pn2d_ram #(.Width(pn2d_pkg::PermWidth), .Depth(pn2d_pkg::PermDepth)) u_ram_a (
    .clk, .we(is_load), .waddr(in_req.perm_index), .wdata(in_req.perm_value),
    .re(adv), .raddr(xi), .rdata(pa));
  pn2d_ram #(.Width(pn2d_pkg::PermWidth), .Depth(pn2d_pkg::PermDepth)) u_ram_b (
    .clk, .we(is_load), .waddr(in_req.perm_index), .wdata(in_req.perm_value),
    .re(adv), .raddr(xi1), .rdata(pb));

  // stage 1 payload
  logic [AW-1:0] s1_y, s1_y1;
  logic [F-1:0] s1_fx, s1_fy;
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_y <= yi;
      s1_y1 <= yi1;
      s1_fx <= fx_in;
      s1_fy <= fy_in;
    end
  end

  // second lookup: four corner hashes
  pn2d_ram #(.Width(pn2d_pkg::PermWidth), .Depth(pn2d_pkg::PermDepth)) u_ram_c0 (
    .clk, .we(is_load), .waddr(in_req.perm_index), .wdata(in_req.perm_value),
    .re(adv), .raddr(pa + s1_y), .rdata(ha0));
  pn2d_ram #(.Width(pn2d_pkg::PermWidth), .Depth(pn2d_pkg::PermDepth)) u_ram_c1 (
    .clk, .we(is_load), .waddr(in_req.perm_index), .wdata(in_req.perm_value),
    .re(adv), .raddr(pa + s1_y1), .rdata(ha1));
  pn2d_ram #(.Width(pn2d_pkg::PermWidth), .Depth(pn2d_pkg::PermDepth)) u_ram_c2 (
    .clk, .we(is_load), .waddr(in_req.perm_index), .wdata(in_req.perm_value),
    .re(adv), .raddr(pb + s1_y), .rdata(hb0));
  pn2d_ram #(.Width(pn2d_pkg::PermWidth), .Depth(pn2d_pkg::PermDepth)) u_ram_c3 (
    .clk, .we(is_load), .waddr(in_req.perm_index), .wdata(in_req.perm_value),
    .re(adv), .raddr(pb + s1_y1), .rdata(hb1));

  // fade pipeline for x and y runs alongside: stages 1..10
  logic signed [DW-1:0] tx0, ty0;
  logic signed [DW-1:0] tx [1:7], ty [1:7];
  logic signed [DW-1:0] rx1, ry1, rx3, ry3, rx5, ry5, rx7, ry7, rx9, ry9;
  logic signed [PW-1:0] px2, py2, px4, py4, px6, py6, px8, py8;

  assign tx0 = DW'({1'b0, fx_in});
  assign ty0 = DW'({1'b0, fy_in});

  // stage 2: dot products once hashes are out
  logic [F-1:0] s2_fx, s2_fy;
  logic signed [DW-1:0] dxs, dys;
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_fx <= s1_fx;
      s2_fy <= s1_fy;
    end
  end
  assign dxs = DW'({1'b0, s2_fx});
  assign dys = DW'({1'b0, s2_fy});

  // corner values carried down the pipe
  logic signed [DW-1:0] c_bl [3:10], c_tl [3:10], c_br [3:10], c_tr [3:10];

  always_ff @(posedge clk) begin
    if (adv) begin
      c_bl[3] <= cdot(ha0[1:0], dxs, dys);
      c_tl[3] <= cdot(ha1[1:0], dxs, dys - One);
      c_br[3] <= cdot(hb0[1:0], dxs - One, dys);
      c_tr[3] <= cdot(hb1[1:0], dxs - One, dys - One);
      for (int i = 4; i <= 10; i++) begin
        c_bl[i] <= c_bl[i-1];
        c_tl[i] <= c_tl[i-1];
        c_br[i] <= c_br[i-1];
        c_tr[i] <= c_tr[i-1];
      end
    end
  end

  // fade by Horner: each step a multiply stage then a round/add stage
  // step A (stage1): r = 6t-15; stages 2..9 four products
  always_ff @(posedge clk) begin
    if (adv) begin
      tx[1] <= tx0;
      ty[1] <= ty0;
      for (int i = 2; i <= 7; i++) begin
        tx[i] <= tx[i-1];
        ty[i] <= ty[i-1];
      end
      rx1 <= DW'(6) * tx0 - Fifteen;
      ry1 <= DW'(6) * ty0 - Fifteen;
      // product 1
      px2 <= PW'(rx1) * PW'(tx[1]);
      py2 <= PW'(ry1) * PW'(ty[1]);
      rx3 <= rnd(px2) + Ten;
      ry3 <= rnd(py2) + Ten;
      // products 2..4
      px4 <= PW'(rx3) * PW'(tx[3]);
      py4 <= PW'(ry3) * PW'(ty[3]);
      rx5 <= rnd(px4);
      ry5 <= rnd(py4);
      px6 <= PW'(rx5) * PW'(tx[5]);
      py6 <= PW'(ry5) * PW'(ty[5]);
      rx7 <= rnd(px6);
      ry7 <= rnd(py6);
      px8 <= PW'(rx7) * PW'(tx[7]);
      py8 <= PW'(ry7) * PW'(ty[7]);
      rx9 <= rnd(px8);
      ry9 <= rnd(py8);
    end
  end

  // clamp fade to [0, 1]
  logic signed [DW-1:0] fu, fv;
  always_ff @(posedge clk) begin
    if (adv) begin
      fu <= (rx9 < 0) ? '0 : ((rx9 > One) ? One : rx9);
      fv <= (ry9 < 0) ? '0 : ((ry9 > One) ? One : ry9);
    end
  end

  // lerp along y: stages 11..12, then along x: 13..14
  logic signed [PW-1:0] p_l, p_r, p_n;
  logic signed [DW-1:0] a_l, a_r, l_l, l_r, fu2, fu3, l_l2, n_v;
  always_ff @(posedge clk) begin
    if (adv) begin
      p_l <= PW'(c_tl[10] - c_bl[10]) * PW'(fv);
      p_r <= PW'(c_tr[10] - c_br[10]) * PW'(fv);
      a_l <= c_bl[10];
      a_r <= c_br[10];
      fu2 <= fu;
      l_l <= a_l + rnd(p_l);
      l_r <= a_r + rnd(p_r);
      fu3 <= fu2;
      p_n <= PW'(l_r - l_l) * PW'(fu3);
      l_l2 <= l_l;
      n_v <= l_l2 + rnd(p_n);
    end
  end

  // rescale to Q2.16 and saturate
  logic signed [DW+OutShift-1:0] n16;
  if (F > pn2d_pkg::OutFrac) begin : g_down
    localparam int unsigned Sh = F - pn2d_pkg::OutFrac;
    assign n16 = (DW+OutShift)'((n_v + (DW'(1) <<< (Sh - 1))) >>> Sh);
  end else begin : g_up
    assign n16 = (DW+OutShift)'(n_v) <<< OutShift;
  end

  logic signed [17:0] n_sat;
  logic signed [DW+OutShift:0] u_sum;
  logic [15:0] u_sat;
  always_comb begin
    if (n16 > (DW+OutShift)'(131071)) begin
      n_sat = 18'sd131071;
    end else if (n16 < -(DW+OutShift)'(131072)) begin
      n_sat = -18'sd131072;
    end else begin
      n_sat = 18'(n16);
    end
    u_sum = (DW+OutShift+1)'(n_sat) + (DW+OutShift+1)'(65537);
    if (u_sum < 0) begin
      u_sat = '0;
    end else if ((u_sum >>> 1) > (DW+OutShift+1)'(65535)) begin
      u_sat = 16'hFFFF;
    end else begin
      u_sat = 16'(u_sum >>> 1);
    end
  end

  // valid pipe, only evaluates flow
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld <= {vld[NS-2:0], take && (in_req.op == pn2d_pkg::OP_EVAL)};
      out_valid <= vld[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res.noise <= n_sat;
      out_res.noise_unit <= u_sat;
    end
  end
  assign out_res.valid = out_valid;

endmodule
